// ===== src/bkts_pkg.sv =====
// ----------------------------------------------------------------------------
// Bond key table store package
// Shared codes, field widths and default sizes for the bond key table store.
// ----------------------------------------------------------------------------
package bkts_pkg;

   // Default sizes
   localparam int SECURITY_DEPTH_DEFAULT     = 8;
   localparam int SUBSCRIPTION_DEPTH_DEFAULT = 16;
   localparam int PAYLOAD_WIDTH_DEFAULT      = 64;

   // Fixed field widths
   localparam int ADDR_WIDTH   = 48;
   localparam int TYPE_WIDTH   = 2;
   localparam int KEY_WIDTH    = ADDR_WIDTH + TYPE_WIDTH;
   localparam int HANDLE_WIDTH = 16;
   localparam int SKIP_WIDTH   = 4;

   // Request actions
   localparam logic [1:0] ACTION_READ   = 2'd0;
   localparam logic [1:0] ACTION_WRITE  = 2'd1;
   localparam logic [1:0] ACTION_DELETE = 2'd2;
   localparam logic [1:0] ACTION_UNUSED = 2'd3;

   // Table selects (the unused code acts on the peer table)
   localparam logic [1:0] TABLE_OWN  = 2'd0;
   localparam logic [1:0] TABLE_PEER = 2'd1;
   localparam logic [1:0] TABLE_SUB  = 2'd2;

   // Response status
   localparam logic [1:0] STATUS_DONE     = 2'd0;
   localparam logic [1:0] STATUS_NO_ENTRY = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

endpackage

// ===== src/bkts_ram.sv =====
// ----------------------------------------------------------------------------
// Generic table RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module bkts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/bond_key_table_store_core.sv =====
// ----------------------------------------------------------------------------
// Bond key table store core
// Own and peer security tables and a subscription table, searched one entry
// per cycle through a registered-read RAM port under a small sequencer.
// ----------------------------------------------------------------------------
// An unused action answers in the cycle after the accepting edge; others
// answer when the scan has covered all entries or stops at a matching one,
// and a delete that hits then moves the last entry via the fetch and move
// states. New requests are taken only while idle; entries are read one per
// cycle through one RAM read port, and busy drops with the strobe. Reset
// clears the counts and the sequencer. The receiver cannot stall.
module bond_key_table_store_core #(
   parameter int SECURITY_DEPTH     = bkts_pkg::SECURITY_DEPTH_DEFAULT,
   parameter int SUBSCRIPTION_DEPTH = bkts_pkg::SUBSCRIPTION_DEPTH_DEFAULT,
   parameter int PAYLOAD_WIDTH      = bkts_pkg::PAYLOAD_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_action,
   input  logic [1:0]                          req_table_select,
   input  logic [bkts_pkg::TYPE_WIDTH-1:0]     req_peer_address_type,
   input  logic [bkts_pkg::ADDR_WIDTH-1:0]     req_peer_address,
   input  logic [bkts_pkg::HANDLE_WIDTH-1:0]   req_attribute_handle,
   input  logic [bkts_pkg::SKIP_WIDTH-1:0]     req_match_skip,
   input  logic [PAYLOAD_WIDTH-1:0]            req_entry_payload,
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_status,
   output logic [bkts_pkg::TYPE_WIDTH-1:0]     rsp_found_address_type,
   output logic [bkts_pkg::ADDR_WIDTH-1:0]     rsp_found_address,
   output logic [bkts_pkg::HANDLE_WIDTH-1:0]   rsp_found_handle,
   output logic [PAYLOAD_WIDTH-1:0]            rsp_found_payload
);

   localparam int KW  = bkts_pkg::KEY_WIDTH;
   localparam int HW  = bkts_pkg::HANDLE_WIDTH;
   localparam int AW  = bkts_pkg::ADDR_WIDTH;
   localparam int SW  = bkts_pkg::SKIP_WIDTH;
   localparam int PW  = PAYLOAD_WIDTH;
   // Security RAM holds both security tables, own first, then peer.
   localparam int SEC_DEPTH = 2 * SECURITY_DEPTH;
   localparam int SAW = (SEC_DEPTH > 1) ? $clog2(SEC_DEPTH) : 1;
   localparam int UAW = (SUBSCRIPTION_DEPTH > 1) ? $clog2(SUBSCRIPTION_DEPTH) : 1;
   localparam int SCW = $clog2(SECURITY_DEPTH + 1);
   localparam int UCW = $clog2(SUBSCRIPTION_DEPTH + 1);
   localparam int CW  = (SCW > UCW) ? SCW : UCW;
   localparam int SEC_W = KW + PW;
   localparam int SUB_W = KW + HW + PW;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_FETCH = 4'b0100,
      ST_MOVE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Captured request
   logic [1:0]    act_ff, act_in;
   logic          sub_sel_ff, sub_sel_in;
   logic          peer_ff, peer_in;
   logic [KW-1:0] key_ff, key_in;
   logic [HW-1:0] handle_ff, handle_in;
   logic [SW-1:0] skip_ff, skip_in;
   logic [PW-1:0] payload_ff, payload_in;

   // Scan sequencer: scan_ff is the next index to read, cmp_ff the index whose
   // data shows on the RAM output when pend_ff is set.
   logic [CW-1:0] scan_ff, scan_in;
   logic [CW-1:0] cmp_ff, cmp_in;
   logic          pend_ff, pend_in;

   // Table fill counts
   logic [SCW-1:0] own_cnt_ff, own_cnt_in;
   logic [SCW-1:0] peer_cnt_ff, peer_cnt_in;
   logic [UCW-1:0] sub_cnt_ff, sub_cnt_in;
   logic           cnt_inc, cnt_dec;

   // Response registers
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [KW-1:0] rsp_key_ff, rsp_key_in;
   logic [HW-1:0] rsp_handle_ff, rsp_handle_in;
   logic [PW-1:0] rsp_payload_ff, rsp_payload_in;

   // Table access
   logic [CW-1:0]    cnt_cur, depth_cur, rd_idx, wr_idx;
   logic             more, hit, stop, wr_en;
   logic [SAW-1:0]   sec_base;
   logic [SAW-1:0]   sec_raddr, sec_waddr;
   logic [SEC_W-1:0] sec_wdata, sec_rdata;
   logic [UAW-1:0]   sub_raddr, sub_waddr;
   logic [SUB_W-1:0] sub_wdata, sub_rdata;
   logic [KW-1:0]    rd_key;
   logic [HW-1:0]    rd_handle;
   logic [PW-1:0]    rd_payload;
   logic             addr_any, handle_any, key_eq, handle_eq;

   // Count and capacity of the table this request works on.
   always_comb begin
      if (sub_sel_ff) begin
         cnt_cur   = CW'(sub_cnt_ff);
         depth_cur = CW'(SUBSCRIPTION_DEPTH);
      end else begin
         cnt_cur   = peer_ff ? CW'(peer_cnt_ff) : CW'(own_cnt_ff);
         depth_cur = CW'(SECURITY_DEPTH);
      end
   end

   assign more = scan_ff < cnt_cur;

   // Unpack the entry on the RAM output.
   always_comb begin
      if (sub_sel_ff) begin
         rd_key     = sub_rdata[SUB_W-1 -: KW];
         rd_handle  = sub_rdata[PW +: HW];
         rd_payload = sub_rdata[PW-1:0];
      end else begin
         rd_key     = sec_rdata[SEC_W-1 -: KW];
         rd_handle  = '0;
         rd_payload = sec_rdata[PW-1:0];
      end
   end

   // Match logic. The zero address is a wildcard on a read of any table and
   // on a delete from the subscription table; the zero handle likewise.
   assign addr_any   = (key_ff[AW-1:0] == '0);
   assign handle_any = (handle_ff == '0);
   assign key_eq     = (rd_key == key_ff);
   assign handle_eq  = (rd_handle == handle_ff);

   always_comb begin
      if (sub_sel_ff) begin
         if (act_ff == bkts_pkg::ACTION_WRITE) begin
            hit = pend_ff && key_eq && handle_eq;
         end else begin
            hit = pend_ff && (addr_any || key_eq) && (handle_any || handle_eq);
         end
      end else begin
         if (act_ff == bkts_pkg::ACTION_READ) begin
            hit = pend_ff && (addr_any || key_eq);
         end else begin
            hit = pend_ff && key_eq;
         end
      end
   end

   // A read hit that still has matches to skip keeps the scan running.
   assign stop = hit && !((act_ff == bkts_pkg::ACTION_READ) && (skip_ff != '0));

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      act_in         = act_ff;
      sub_sel_in     = sub_sel_ff;
      peer_in        = peer_ff;
      key_in         = key_ff;
      handle_in      = handle_ff;
      skip_in        = skip_ff;
      payload_in     = payload_ff;
      scan_in        = scan_ff;
      cmp_in         = cmp_ff;
      pend_in        = 1'b0;
      cnt_inc        = 1'b0;
      cnt_dec        = 1'b0;
      wr_en          = 1'b0;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = bkts_pkg::STATUS_NO_ENTRY;
      rsp_key_in     = '0;
      rsp_handle_in  = '0;
      rsp_payload_in = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_action == bkts_pkg::ACTION_UNUSED) begin
                  rsp_valid_in = 1'b1;
               end else begin
                  act_in     = req_action;
                  sub_sel_in = (req_table_select == bkts_pkg::TABLE_SUB);
                  peer_in    = (req_table_select != bkts_pkg::TABLE_OWN);
                  key_in     = {req_peer_address_type, req_peer_address};
                  handle_in  = req_attribute_handle;
                  skip_in    = req_match_skip;
                  payload_in = req_entry_payload;
                  scan_in    = '0;
                  state_in   = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            if (hit) begin
               case (act_ff)
                  bkts_pkg::ACTION_READ: begin
                     if (skip_ff == '0) begin
                        rsp_valid_in   = 1'b1;
                        rsp_status_in  = bkts_pkg::STATUS_DONE;
                        rsp_key_in     = rd_key;
                        rsp_handle_in  = rd_handle;
                        rsp_payload_in = rd_payload;
                        state_in       = ST_IDLE;
                     end else begin
                        skip_in = skip_ff - SW'(1);
                     end
                  end
                  bkts_pkg::ACTION_WRITE: begin
                     wr_en         = 1'b1;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = bkts_pkg::STATUS_DONE;
                     state_in      = ST_IDLE;
                  end
                  bkts_pkg::ACTION_DELETE: begin
                     state_in = ST_FETCH;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end
               endcase
            end else if (!pend_ff && !more) begin
               // Scan done without a usable match.
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (act_ff == bkts_pkg::ACTION_WRITE) begin
                  if (cnt_cur >= depth_cur) begin
                     rsp_status_in = bkts_pkg::STATUS_FULL;
                  end else begin
                     wr_en         = 1'b1;
                     cnt_inc       = 1'b1;
                     rsp_status_in = bkts_pkg::STATUS_DONE;
                  end
               end
            end
            if (!stop && more) begin
               scan_in = scan_ff + CW'(1);
               cmp_in  = scan_ff;
               pend_in = 1'b1;
            end
         end

         ST_FETCH: begin
            // The last entry is read this cycle and moved next cycle.
            state_in = ST_MOVE;
         end

         ST_MOVE: begin
            wr_en         = 1'b1;
            cnt_dec       = 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_status_in = bkts_pkg::STATUS_DONE;
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Count updates for the selected table.
   always_comb begin
      own_cnt_in  = own_cnt_ff;
      peer_cnt_in = peer_cnt_ff;
      sub_cnt_in  = sub_cnt_ff;
      if (sub_sel_ff) begin
         if (cnt_inc) begin
            sub_cnt_in = sub_cnt_ff + UCW'(1);
         end else if (cnt_dec) begin
            sub_cnt_in = sub_cnt_ff - UCW'(1);
         end
      end else if (peer_ff) begin
         if (cnt_inc) begin
            peer_cnt_in = peer_cnt_ff + SCW'(1);
         end else if (cnt_dec) begin
            peer_cnt_in = peer_cnt_ff - SCW'(1);
         end
      end else begin
         if (cnt_inc) begin
            own_cnt_in = own_cnt_ff + SCW'(1);
         end else if (cnt_dec) begin
            own_cnt_in = own_cnt_ff - SCW'(1);
         end
      end
   end

   // RAM addressing. A write lands on the matched entry, on the deleted
   // entry's slot, or at the end of the table when appending.
   assign rd_idx   = (state_ff == ST_FETCH) ? (cnt_cur - CW'(1)) : scan_ff;
   assign wr_idx   = ((state_ff == ST_MOVE) || hit) ? cmp_ff : cnt_cur;
   assign sec_base = peer_ff ? SAW'(SECURITY_DEPTH) : '0;

   assign sec_raddr = sec_base + SAW'(rd_idx);
   assign sec_waddr = sec_base + SAW'(wr_idx);
   assign sub_raddr = UAW'(rd_idx);
   assign sub_waddr = UAW'(wr_idx);

   assign sec_wdata = (state_ff == ST_MOVE) ? sec_rdata : {key_ff, payload_ff};
   assign sub_wdata = (state_ff == ST_MOVE) ? sub_rdata : {key_ff, handle_ff, payload_ff};

   bkts_ram #(
      .WIDTH (SEC_W),
      .DEPTH (SEC_DEPTH)
   ) u_sec_ram (
      .clock   (clock),
      .wr_en   (wr_en && !sub_sel_ff),
      .wr_addr (sec_waddr),
      .wr_data (sec_wdata),
      .rd_addr (sec_raddr),
      .rd_data (sec_rdata)
   );

   bkts_ram #(
      .WIDTH (SUB_W),
      .DEPTH (SUBSCRIPTION_DEPTH)
   ) u_sub_ram (
      .clock   (clock),
      .wr_en   (wr_en && sub_sel_ff),
      .wr_addr (sub_waddr),
      .wr_data (sub_wdata),
      .rd_addr (sub_raddr),
      .rd_data (sub_rdata)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         own_cnt_ff   <= '0;
         peer_cnt_ff  <= '0;
         sub_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         own_cnt_ff   <= own_cnt_in;
         peer_cnt_ff  <= peer_cnt_in;
         sub_cnt_ff   <= sub_cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      act_ff         <= act_in;
      sub_sel_ff     <= sub_sel_in;
      peer_ff        <= peer_in;
      key_ff         <= key_in;
      handle_ff      <= handle_in;
      skip_ff        <= skip_in;
      payload_ff     <= payload_in;
      scan_ff        <= scan_in;
      cmp_ff         <= cmp_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_key_ff     <= rsp_key_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign busy                   = (state_ff != ST_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_found_address_type = rsp_key_ff[KW-1 -: bkts_pkg::TYPE_WIDTH];
   assign rsp_found_address      = rsp_key_ff[AW-1:0];
   assign rsp_found_handle       = rsp_handle_ff;
   assign rsp_found_payload      = rsp_payload_ff;

endmodule

// ===== src/bkts_checker.sv =====
// ----------------------------------------------------------------------------
// Bond key table store checker
// Port-level assertions on the core, attached by a bind statement.
// ----------------------------------------------------------------------------
module bkts_checker #(
   parameter int PAYLOAD_WIDTH = bkts_pkg::PAYLOAD_WIDTH_DEFAULT
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic [1:0]                        req_action,
   input logic [1:0]                        req_table_select,
   input logic [bkts_pkg::TYPE_WIDTH-1:0]   req_peer_address_type,
   input logic [bkts_pkg::ADDR_WIDTH-1:0]   req_peer_address,
   input logic [bkts_pkg::HANDLE_WIDTH-1:0] req_attribute_handle,
   input logic [bkts_pkg::SKIP_WIDTH-1:0]   req_match_skip,
   input logic [PAYLOAD_WIDTH-1:0]          req_entry_payload,
   input logic                              rsp_valid,
   input logic [1:0]                        rsp_status,
   input logic [bkts_pkg::TYPE_WIDTH-1:0]   rsp_found_address_type,
   input logic [bkts_pkg::ADDR_WIDTH-1:0]   rsp_found_address,
   input logic [bkts_pkg::HANDLE_WIDTH-1:0] rsp_found_handle,
   input logic [PAYLOAD_WIDTH-1:0]          rsp_found_payload
);

   // A result always coincides with the block being free again.
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobed while busy");

   // An unused action is answered at once with no entry, and keeps busy low.
   a_unused_action: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == bkts_pkg::ACTION_UNUSED))
      |=> (rsp_valid && !busy && (rsp_status == bkts_pkg::STATUS_NO_ENTRY)))
      else $error("unused action not answered with no entry");

   // Any other accepted request makes the block busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action != bkts_pkg::ACTION_UNUSED)) |=> busy)
      else $error("accepted request did not raise busy");

   // Only a successful transfer carries found fields.
   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != bkts_pkg::STATUS_DONE))
      |-> ((rsp_found_address_type == '0) && (rsp_found_address == '0) &&
           (rsp_found_handle == '0) && (rsp_found_payload == '0)))
      else $error("found fields not zero on a failed request");

endmodule

bind bond_key_table_store_core bkts_checker #(
   .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
) u_bkts_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bond key table store testbench
// Sends a directed set of requests and then bursts of random requests to the
// table store, predicts every answer with a model of the three tables kept
// here, and checks each response field against that prediction.
// ----------------------------------------------------------------------------
module tb;

   localparam int SEC_DEPTH = bkts_pkg::SECURITY_DEPTH_DEFAULT;
   localparam int SUB_DEPTH = bkts_pkg::SUBSCRIPTION_DEPTH_DEFAULT;
   localparam int PAY_WIDTH = bkts_pkg::PAYLOAD_WIDTH_DEFAULT;
   localparam int TYPE_WIDTH   = bkts_pkg::TYPE_WIDTH;
   localparam int ADDR_WIDTH   = bkts_pkg::ADDR_WIDTH;
   localparam int KEY_WIDTH    = bkts_pkg::KEY_WIDTH;
   localparam int HANDLE_WIDTH = bkts_pkg::HANDLE_WIDTH;
   localparam int SKIP_WIDTH   = bkts_pkg::SKIP_WIDTH;
   localparam int RANDOM_REQUESTS = 750;

   // The fourth table code has no name in the package; the block treats it
   // as the peer security table.
   localparam logic [1:0] TABLE_UNUSED = 2'd3;

   typedef enum {BURST_FILL, BURST_MIXED, BURST_DRAIN} burst_kind_type;

   typedef struct {
      logic [1:0]              action;
      logic [1:0]              table_sel;
      logic [TYPE_WIDTH-1:0]   addr_type;
      logic [ADDR_WIDTH-1:0]   addr;
      logic [HANDLE_WIDTH-1:0] handle;
      logic [SKIP_WIDTH-1:0]   skip;
      logic [PAY_WIDTH-1:0]    payload;
      int                      gap_after;
      bit                      wait_idle;
   } bond_request_type;

   typedef struct packed {
      logic [1:0]              status;
      logic [TYPE_WIDTH-1:0]   addr_type;
      logic [ADDR_WIDTH-1:0]   addr;
      logic [HANDLE_WIDTH-1:0] handle;
      logic [PAY_WIDTH-1:0]    payload;
   } bond_response_type;

   typedef struct {
      logic [1:0]              table_sel;
      logic [TYPE_WIDTH-1:0]   addr_type;
      logic [ADDR_WIDTH-1:0]   addr;
      logic [HANDLE_WIDTH-1:0] handle;
   } key_ref_type;

   // Clock, reset and the ports of the block.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0]              req_action = '0;
   logic [1:0]              req_table_select = '0;
   logic [TYPE_WIDTH-1:0]   req_peer_address_type = '0;
   logic [ADDR_WIDTH-1:0]   req_peer_address = '0;
   logic [HANDLE_WIDTH-1:0] req_attribute_handle = '0;
   logic [SKIP_WIDTH-1:0]   req_match_skip = '0;
   logic [PAY_WIDTH-1:0]    req_entry_payload = '0;
   logic                    rsp_valid;
   logic [1:0]              rsp_status;
   logic [TYPE_WIDTH-1:0]   rsp_found_address_type;
   logic [ADDR_WIDTH-1:0]   rsp_found_address;
   logic [HANDLE_WIDTH-1:0] rsp_found_handle;
   logic [PAY_WIDTH-1:0]    rsp_found_payload;

   // Requests waiting to be sent, and answers predicted for accepted requests.
   bond_request_type  queued_requests[$];
   bond_response_type predicted_answers[$];
   // Number of predicted answers still open, as of the last clock edge. Only
   // the monitor writes it, so the driver and the end-of-run wait can read it
   // without racing the monitor.
   int             in_flight = 0;
   int             mismatch_count = 0;
   int             idle_left = 0;

   // Shadow copy of the tables. The security arrays hold the own table in the
   // low half and the peer table in the high half, as the block does.
   logic [KEY_WIDTH-1:0]    sec_key [2*SEC_DEPTH];
   logic [PAY_WIDTH-1:0]    sec_pay [2*SEC_DEPTH];
   int                      sec_count [2] = '{0, 0};
   logic [KEY_WIDTH-1:0]    sub_key [SUB_DEPTH];
   logic [HANDLE_WIDTH-1:0] sub_hnd [SUB_DEPTH];
   logic [PAY_WIDTH-1:0]    sub_pay [SUB_DEPTH];
   int                      sub_count = 0;

   // Stimulus helpers: a few fixed addresses and handles so that keys repeat,
   // and the most recently written keys so that reads and deletes hit.
   logic [ADDR_WIDTH-1:0]   addr_pool [4];
   logic [HANDLE_WIDTH-1:0] handle_pool [4];
   key_ref_type             recent_keys[$];

   bond_key_table_store_core dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_action             (req_action),
      .req_table_select       (req_table_select),
      .req_peer_address_type  (req_peer_address_type),
      .req_peer_address       (req_peer_address),
      .req_attribute_handle   (req_attribute_handle),
      .req_match_skip         (req_match_skip),
      .req_entry_payload      (req_entry_payload),
      .rsp_valid              (rsp_valid),
      .rsp_status             (rsp_status),
      .rsp_found_address_type (rsp_found_address_type),
      .rsp_found_address      (rsp_found_address),
      .rsp_found_handle       (rsp_found_handle),
      .rsp_found_payload      (rsp_found_payload)
   );

   always #5 clock = ~clock;

   // A subscription entry matches a read or a delete when the address is zero
   // or the whole key is equal, and when the handle is zero or equal.
   function automatic bit sub_hit(input int i, input logic [KEY_WIDTH-1:0] key,
                                  input logic [HANDLE_WIDTH-1:0] hnd);
      if (key[ADDR_WIDTH-1:0] != '0 && sub_key[i] != key) return 1'b0;
      if (hnd != '0 && sub_hnd[i] != hnd) return 1'b0;
      return 1'b1;
   endfunction

   // Applies one accepted request to the shadow tables and returns the answer
   // the block must give for it.
   function automatic bond_response_type apply_table_request(input bond_request_type rq);
      bond_response_type    rs;
      logic [KEY_WIDTH-1:0] key;
      int                   slot;
      int                   base;
      int                   n;
      int                   skip_left;
      int                   i;
      bit                   any_addr;
      rs = '0;
      rs.status = bkts_pkg::STATUS_DONE;
      key = {rq.addr_type, rq.addr};
      skip_left = rq.skip;
      any_addr = (rq.addr == '0);
      if (rq.action == bkts_pkg::ACTION_UNUSED) begin
         rs.status = bkts_pkg::STATUS_NO_ENTRY;
         return rs;
      end
      if (rq.table_sel == bkts_pkg::TABLE_SUB) begin
         n = sub_count;
         case (rq.action)
            bkts_pkg::ACTION_READ: begin
               for (i = 0; i < n; i++) begin
                  if (!sub_hit(i, key, rq.handle)) continue;
                  if (skip_left > 0) begin
                     skip_left--;
                     continue;
                  end
                  rs.addr_type = sub_key[i][KEY_WIDTH-1:ADDR_WIDTH];
                  rs.addr = sub_key[i][ADDR_WIDTH-1:0];
                  rs.handle = sub_hnd[i];
                  rs.payload = sub_pay[i];
                  return rs;
               end
               rs.status = bkts_pkg::STATUS_NO_ENTRY;
            end
            bkts_pkg::ACTION_WRITE: begin
               // A write needs an exact match of key and handle to update.
               for (i = 0; i < n; i++) begin
                  if (sub_key[i] == key && sub_hnd[i] == rq.handle) begin
                     sub_pay[i] = rq.payload;
                     return rs;
                  end
               end
               if (n >= SUB_DEPTH) begin
                  rs.status = bkts_pkg::STATUS_FULL;
               end else begin
                  sub_key[n] = key;
                  sub_hnd[n] = rq.handle;
                  sub_pay[n] = rq.payload;
                  sub_count = n + 1;
               end
            end
            default: begin
               // Delete: the last entry moves into the freed slot.
               for (i = 0; i < n; i++) begin
                  if (sub_hit(i, key, rq.handle)) begin
                     n--;
                     sub_key[i] = sub_key[n];
                     sub_hnd[i] = sub_hnd[n];
                     sub_pay[i] = sub_pay[n];
                     sub_count = n;
                     return rs;
                  end
               end
               rs.status = bkts_pkg::STATUS_NO_ENTRY;
            end
         endcase
         return rs;
      end
      // Security tables; the unused table code lands on the peer table.
      slot = (rq.table_sel == bkts_pkg::TABLE_OWN) ? 0 : 1;
      base = slot * SEC_DEPTH;
      n = sec_count[slot];
      case (rq.action)
         bkts_pkg::ACTION_READ: begin
            // The zero address is a wildcard on reads only, and then the type
            // is ignored as well.
            for (i = 0; i < n; i++) begin
               if (!any_addr && sec_key[base+i] != key) continue;
               if (skip_left > 0) begin
                  skip_left--;
                  continue;
               end
               rs.addr_type = sec_key[base+i][KEY_WIDTH-1:ADDR_WIDTH];
               rs.addr = sec_key[base+i][ADDR_WIDTH-1:0];
               rs.payload = sec_pay[base+i];
               return rs;
            end
            rs.status = bkts_pkg::STATUS_NO_ENTRY;
         end
         bkts_pkg::ACTION_WRITE: begin
            for (i = 0; i < n; i++) begin
               if (sec_key[base+i] == key) begin
                  sec_pay[base+i] = rq.payload;
                  return rs;
               end
            end
            if (n >= SEC_DEPTH) begin
               rs.status = bkts_pkg::STATUS_FULL;
            end else begin
               sec_key[base+n] = key;
               sec_pay[base+n] = rq.payload;
               sec_count[slot] = n + 1;
            end
         end
         default: begin
            for (i = 0; i < n; i++) begin
               if (sec_key[base+i] == key) begin
                  n--;
                  sec_key[base+i] = sec_key[base+n];
                  sec_pay[base+i] = sec_pay[base+n];
                  sec_count[slot] = n;
                  return rs;
               end
            end
            rs.status = bkts_pkg::STATUS_NO_ENTRY;
         end
      endcase
      return rs;
   endfunction

   task automatic add_directed(input logic [1:0] act, input logic [1:0] tsel,
                               input logic [1:0] atype, input logic [47:0] addr,
                               input logic [15:0] hnd, input logic [3:0] skip,
                               input logic [63:0] payload, input bit hold = 1'b0);
      bond_request_type rq;
      rq.action = act;
      rq.table_sel = tsel;
      rq.addr_type = atype;
      rq.addr = addr;
      rq.handle = hnd;
      rq.skip = skip;
      rq.payload = payload;
      rq.gap_after = $urandom_range(2);
      rq.wait_idle = hold;
      queued_requests.push_back(rq);
   endtask

   // One random request. A fill burst writes mostly, a drain burst deletes
   // mostly, so the tables swing between empty and full. About half of the
   // requests reuse a key written not long ago so that searches find entries.
   function automatic bond_request_type random_request(input burst_kind_type kind,
                                                       input logic [1:0] focus);
      bond_request_type rq;
      key_ref_type      ref_key;
      int               pick;
      pick = $urandom_range(99);
      case (kind)
         BURST_FILL:
            rq.action = pick < 75 ? bkts_pkg::ACTION_WRITE :
                        pick < 88 ? bkts_pkg::ACTION_READ :
                        pick < 97 ? bkts_pkg::ACTION_DELETE : bkts_pkg::ACTION_UNUSED;
         BURST_MIXED:
            rq.action = pick < 30 ? bkts_pkg::ACTION_WRITE :
                        pick < 70 ? bkts_pkg::ACTION_READ :
                        pick < 96 ? bkts_pkg::ACTION_DELETE : bkts_pkg::ACTION_UNUSED;
         default:
            rq.action = pick < 15 ? bkts_pkg::ACTION_WRITE :
                        pick < 45 ? bkts_pkg::ACTION_READ :
                        pick < 96 ? bkts_pkg::ACTION_DELETE : bkts_pkg::ACTION_UNUSED;
      endcase
      rq.table_sel = ($urandom_range(99) < 80) ? focus : 2'($urandom_range(3));
      if (recent_keys.size() != 0 && $urandom_range(99) < 50) begin
         ref_key = recent_keys[$urandom_range(recent_keys.size() - 1)];
         rq.table_sel = ref_key.table_sel;
         rq.addr_type = ref_key.addr_type;
         rq.addr = ref_key.addr;
         rq.handle = ref_key.handle;
      end else begin
         rq.addr_type = 2'($urandom_range(3));
         if ($urandom_range(99) < 85) rq.addr = addr_pool[$urandom_range(3)];
         else rq.addr = {16'($urandom), 32'($urandom)};
         if ($urandom_range(99) < 75) rq.handle = handle_pool[$urandom_range(3)];
         else rq.handle = 16'($urandom);
      end
      // Wildcard searches on reads and deletes.
      if (rq.action != bkts_pkg::ACTION_WRITE && $urandom_range(99) < 25) rq.addr = '0;
      if (rq.action != bkts_pkg::ACTION_WRITE && $urandom_range(99) < 20) rq.handle = '0;
      pick = $urandom_range(99);
      if (pick < 70) rq.skip = '0;
      else if (pick < 90) rq.skip = 4'($urandom_range(1, 3));
      else rq.skip = 4'($urandom_range(15));
      rq.payload = {$urandom, $urandom};
      rq.gap_after = 0;
      rq.wait_idle = 1'b0;
      if (rq.action == bkts_pkg::ACTION_WRITE) begin
         ref_key.table_sel = rq.table_sel;
         ref_key.addr_type = rq.addr_type;
         ref_key.addr = rq.addr;
         ref_key.handle = rq.handle;
         recent_keys.push_back(ref_key);
         if (recent_keys.size() > 8) void'(recent_keys.pop_front());
      end
      return rq;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Driver. A request stays on the ports until the edge that accepts it;
   // the next one follows at once unless the accepted one drew an idle gap. A
   // request marked wait_idle is held back until no answer is outstanding.
   always @(posedge clock) begin
      bond_request_type next_rq;
      if (reset) begin
         start <= 1'b0;
         idle_left <= 0;
      end else if (!start || !busy) begin
         if (idle_left > 0) begin
            start <= 1'b0;
            idle_left <= idle_left - 1;
         end else if (queued_requests.size() != 0 &&
                      !(queued_requests[0].wait_idle && (start || in_flight != 0))) begin
            next_rq = queued_requests.pop_front();
            start <= 1'b1;
            req_action <= next_rq.action;
            req_table_select <= next_rq.table_sel;
            req_peer_address_type <= next_rq.addr_type;
            req_peer_address <= next_rq.addr;
            req_attribute_handle <= next_rq.handle;
            req_match_skip <= next_rq.skip;
            req_entry_payload <= next_rq.payload;
            idle_left <= next_rq.gap_after;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor. Checks the strobed answer against the oldest prediction first,
   // then predicts the answer for a request accepted at this edge. An answer
   // always comes at a later edge than the one that accepts its request, so the
   // order of the two steps cannot matter.
   always @(posedge clock) begin
      bond_request_type  seen;
      bond_response_type want;
      if (reset) begin
         in_flight <= 0;
      end else begin
         if (rsp_valid === 1'b1) begin
            if (predicted_answers.size() == 0) begin
               $error("unexpected response, status %0d", rsp_status);
               mismatch_count++;
            end else begin
               want = predicted_answers.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("found_address_type", want.addr_type,
                           rsp_found_address_type);
               check_field("found_address", want.addr, rsp_found_address);
               check_field("found_handle", want.handle, rsp_found_handle);
               check_field("found_payload", want.payload, rsp_found_payload);
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            seen.action = req_action;
            seen.table_sel = req_table_select;
            seen.addr_type = req_peer_address_type;
            seen.addr = req_peer_address;
            seen.handle = req_attribute_handle;
            seen.skip = req_match_skip;
            seen.payload = req_entry_payload;
            seen.gap_after = 0;
            seen.wait_idle = 1'b0;
            predicted_answers.push_back(apply_table_request(seen));
         end
         in_flight <= predicted_answers.size();
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      burst_kind_type   kind;
      logic [1:0]       focus;
      bond_request_type rq;
      bit               steady;
      int               len;
      int               k;
      int               pick;

      addr_pool[0] = '0;
      addr_pool[1] = '1;
      addr_pool[2] = {16'($urandom), 32'($urandom)};
      addr_pool[3] = {16'($urandom), 32'($urandom)};
      handle_pool[0] = '0;
      handle_pool[1] = 16'd1;
      handle_pool[2] = '1;
      handle_pool[3] = 16'($urandom);

      // Directed part: empty tables, the unused action, updates, wildcard and
      // skipped reads, a skip past the last match, a type mismatch, deletes
      // that hit and miss, the unused table code, and subscription wildcards.
      add_directed(bkts_pkg::ACTION_READ, bkts_pkg::TABLE_OWN, 2'd0, '0, '0, '0, '0);
      add_directed(bkts_pkg::ACTION_UNUSED, bkts_pkg::TABLE_SUB, 2'd3, '1, '1, '1, '1);
      add_directed(bkts_pkg::ACTION_WRITE, bkts_pkg::TABLE_OWN, 2'd3, '1, '0, '0, '1);
      add_directed(bkts_pkg::ACTION_WRITE, bkts_pkg::TABLE_OWN, 2'd0, '0, '0, '0, '0);
      add_directed(bkts_pkg::ACTION_WRITE, bkts_pkg::TABLE_OWN, 2'd3, '1, '1, '0,
                   64'h0123_4567_89AB_CDEF);
      add_directed(bkts_pkg::ACTION_READ, bkts_pkg::TABLE_OWN, 2'd1, '0, '0, 4'd0, '0);
      add_directed(bkts_pkg::ACTION_READ, bkts_pkg::TABLE_OWN, 2'd0, '0, '0, 4'd1, '0);
      add_directed(bkts_pkg::ACTION_READ, bkts_pkg::TABLE_OWN, 2'd0, '0, '0, 4'd15, '0);
      add_directed(bkts_pkg::ACTION_READ, bkts_pkg::TABLE_OWN, 2'd2, '1, '0, 4'd0, '0);
      add_directed(bkts_pkg::ACTION_READ, bkts_pkg::TABLE_OWN, 2'd3, '1, '0, 4'd0, '0);
      add_directed(bkts_pkg::ACTION_DELETE, bkts_pkg::TABLE_OWN, 2'd3, '1, '0, '0, '0);
      add_directed(bkts_pkg::ACTION_DELETE, bkts_pkg::TABLE_OWN, 2'd3, '1, '0, '0, '0);
      add_directed(bkts_pkg::ACTION_WRITE, TABLE_UNUSED, 2'd1, 48'h5555_5555_5555, '0, '0,
                   64'hAAAA_5555_AAAA_5555);
      add_directed(bkts_pkg::ACTION_READ, bkts_pkg::TABLE_PEER, 2'd0, '0, '0, '0, '0);
      add_directed(bkts_pkg::ACTION_WRITE, bkts_pkg::TABLE_SUB, 2'd2, 48'hAAAA_AAAA_AAAA,
                   '1, '0, 64'h5555_AAAA_5555_AAAA);
      add_directed(bkts_pkg::ACTION_WRITE, bkts_pkg::TABLE_SUB, 2'd2, 48'hAAAA_AAAA_AAAA,
                   '0, '0, 64'hFEDC_BA98_7654_3210);
      add_directed(bkts_pkg::ACTION_WRITE, bkts_pkg::TABLE_SUB, 2'd0, '0, 16'd1, '0, 64'h1);
      add_directed(bkts_pkg::ACTION_READ, bkts_pkg::TABLE_SUB, 2'd0, '0, '1, '0, '0);
      add_directed(bkts_pkg::ACTION_READ, bkts_pkg::TABLE_SUB, 2'd2, 48'hAAAA_AAAA_AAAA,
                   '0, 4'd1, '0);
      add_directed(bkts_pkg::ACTION_READ, bkts_pkg::TABLE_SUB, 2'd0, '0, '0, 4'd2, '0);
      add_directed(bkts_pkg::ACTION_DELETE, bkts_pkg::TABLE_SUB, 2'd0, '0, '0, '0, '0);
      // This one also makes the sender wait until every answer is in.
      add_directed(bkts_pkg::ACTION_UNUSED, bkts_pkg::TABLE_OWN, 2'd0, '0, '0, '0, '0, 1'b1);
      add_directed(bkts_pkg::ACTION_DELETE, bkts_pkg::TABLE_SUB, 2'd2, 48'hAAAA_AAAA_AAAA,
                   16'd5, '0, '0);
      add_directed(bkts_pkg::ACTION_READ, bkts_pkg::TABLE_OWN, 2'd0, '0, '0, '0, '0);

      // Random part in bursts, each with one kind and one favored table. Some
      // bursts run back to back with no gaps; elsewhere gaps are mostly short
      // with an occasional long one.
      while (queued_requests.size() < RANDOM_REQUESTS) begin
         kind = burst_kind_type'($urandom_range(2));
         focus = 2'($urandom_range(2));
         steady = ($urandom_range(3) == 0);
         len = $urandom_range(15, 40);
         for (k = 0; k < len; k++) begin
            rq = random_request(kind, focus);
            rq.wait_idle = (k == 0) && ($urandom_range(2) == 0);
            pick = $urandom_range(99);
            if (steady || pick < 65) rq.gap_after = 0;
            else if (pick < 93) rq.gap_after = $urandom_range(1, 3);
            else rq.gap_after = $urandom_range(8, 40);
            queued_requests.push_back(rq);
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Sample at the falling edge, away from any update by the driver or
      // the monitor.
      do @(negedge clock);
      while (queued_requests.size() != 0 || start || in_flight != 0);
      // Anything arriving in this window is an answer nobody asked for.
      repeat (40) @(posedge clock);
      if (predicted_answers.size() != 0) begin
         $error("%0d expected responses never arrived", predicted_answers.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog: a correct run takes well under a millisecond.
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
